/* rtl/etfd_pkg.sv */
// Shared constants, types and the CRC-8 step function for the telemetry frame decoder.
package etfd_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int CRC_W   = 8;
    localparam int POS_W   = 4;

    localparam logic [CRC_W-1:0] CRC_POLY = 8'h07;
    localparam logic [CRC_W-1:0] CRC_TOP  = 8'h80;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_TEMP    = 4'd0;
    localparam t_pos POS_VOLT_HI = 4'd1;
    localparam t_pos POS_VOLT_LO = 4'd2;
    localparam t_pos POS_CURR_HI = 4'd3;
    localparam t_pos POS_CURR_LO = 4'd4;
    localparam t_pos POS_CONS_HI = 4'd5;
    localparam t_pos POS_CONS_LO = 4'd6;
    localparam t_pos POS_SPD_HI  = 4'd7;
    localparam t_pos POS_SPD_LO  = 4'd8;
    localparam t_pos POS_CRC     = 4'd9;

    // MSB-first, unreflected CRC-8 over one byte
    function automatic logic [CRC_W-1:0] crc8_step(input logic [CRC_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] r;
        r = acc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if ((r & CRC_TOP) != '0) begin
                r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

/* rtl/etfd_if.sv */
// Valid/ready channel interfaces for received bytes and decoded frames.
interface etfd_byte_if
    import etfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface etfd_frame_if
    import etfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] temperature;
    logic [WORD_W-1:0] voltage;
    logic [WORD_W-1:0] current;
    logic [WORD_W-1:0] consumption;
    logic [WORD_W-1:0] speed_raw;
    logic [CRC_W-1:0]  crc_remainder;
    logic              frame_ok;

    modport source (output valid, output temperature, output voltage, output current,
                    output consumption, output speed_raw, output crc_remainder,
                    output frame_ok, input ready);
    modport sink   (input valid, input temperature, input voltage, input current,
                    input consumption, input speed_raw, input crc_remainder,
                    input frame_ok, output ready);
endinterface

/* rtl/esc_telemetry_frame_decoder.sv */
// Telemetry frame decoder: assembles ten-byte frames and checks their CRC-8.
// One byte is taken per clock cycle whenever i_byte.ready is high. Each byte updates
// the running CRC-8 (poly 0x07, init 0) and the field holding registers in the same
// cycle; after the tenth byte the decoded frame is loaded into an output register and
// appears on o_frame in the cycle after the last byte's transfer. The output register
// decouples the sides: bytes keep flowing while a frame waits, and input stalls only
// when a finished frame is unclaimed and the next byte would complete another frame.
// There is no resynchronization: a lost or extra byte shifts the framing and
// shows up as frame_ok low.
module esc_telemetry_frame_decoder
    import etfd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    etfd_byte_if.sink     i_byte,
    etfd_frame_if.source  o_frame
);

    t_pos              r_pos, n_pos;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_temp;
    logic [WORD_W-1:0] r_volt, r_curr, r_cons, r_speed;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_temp;
    logic [WORD_W-1:0] r_out_volt, r_out_curr, r_out_cons, r_out_speed;
    logic [CRC_W-1:0]  r_out_crc;
    logic              r_out_ok;

    logic              in_xfer;
    logic              last_byte;
    logic [BYTE_W-1:0] b;

    assign b         = i_byte.data_byte;
    assign i_byte.ready = !r_out_valid || o_frame.ready || !last_byte;
    assign in_xfer   = i_byte.valid && i_byte.ready;
    assign last_byte = (r_pos >= POS_CRC);
    assign n_crc     = crc8_step(r_crc, b);
    assign n_pos     = last_byte ? POS_TEMP : r_pos + t_pos'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_TEMP;
            r_crc <= '0;
        end else if (in_xfer) begin
            r_pos <= n_pos;
            r_crc <= last_byte ? '0 : n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            case (r_pos)
                POS_TEMP:    r_temp          <= b;
                POS_VOLT_HI: r_volt[15:8]    <= b;
                POS_VOLT_LO: r_volt[7:0]     <= b;
                POS_CURR_HI: r_curr[15:8]    <= b;
                POS_CURR_LO: r_curr[7:0]     <= b;
                POS_CONS_HI: r_cons[15:8]    <= b;
                POS_CONS_LO: r_cons[7:0]     <= b;
                POS_SPD_HI:  r_speed[15:8]   <= b;
                POS_SPD_LO:  r_speed[7:0]    <= b;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && last_byte) begin
            r_out_temp  <= r_temp;
            r_out_volt  <= r_volt;
            r_out_curr  <= r_curr;
            r_out_cons  <= r_cons;
            r_out_speed <= r_speed;
            r_out_crc   <= n_crc;
            r_out_ok    <= (n_crc == '0);
        end
    end

    assign o_frame.valid         = r_out_valid;
    assign o_frame.temperature   = r_out_temp;
    assign o_frame.voltage       = r_out_volt;
    assign o_frame.current       = r_out_curr;
    assign o_frame.consumption   = r_out_cons;
    assign o_frame.speed_raw     = r_out_speed;
    assign o_frame.crc_remainder = r_out_crc;
    assign o_frame.frame_ok      = r_out_ok;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_CRC)
        else $error("byte position out of range");

    a_crc_clear_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_TEMP) |-> (r_crc == '0))
        else $error("crc not cleared at frame start");

    a_frame_done_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && last_byte) |=> (r_out_valid && r_pos == POS_TEMP))
        else $error("frame completion did not load output and restart");

    a_ok_matches_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_ok == (r_out_crc == '0)))
        else $error("frame_ok disagrees with crc remainder");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_frame.ready) |-> !(in_xfer && last_byte))
        else $error("frame completed while pending frame is stalled");

endmodule
